>>> hdl/bcdac_pkg.sv
// ----------------------------------------------------------------------------
// bcdac_pkg
// Shared types, command and key codes, and digit helpers for the BCD alarm
// clock.
// ----------------------------------------------------------------------------
`default_nettype none

package bcdac_pkg;

  // Transaction command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_KEY  = 2'd1;
  localparam logic [1:0] CMD_LOAD = 2'd2;

  // Key codes
  localparam logic [7:0] KEY_ENTER   = 8'd13;
  localparam logic [7:0] KEY_SPACE   = 8'd32;
  localparam logic [7:0] KEY_ZERO    = 8'd48;
  localparam logic [7:0] KEY_NINE    = 8'd57;
  localparam logic [7:0] KEY_ENABLE  = 8'd97;
  localparam logic [7:0] KEY_SILENCE = 8'd115;

  // Alarm digit slots in entry order
  localparam int unsigned ALM_HOUR_TENS   = 0;
  localparam int unsigned ALM_HOUR_UNITS  = 1;
  localparam int unsigned ALM_MIN_TENS    = 2;
  localparam int unsigned ALM_MIN_UNITS   = 3;

  typedef logic [3:0] digit_t;
  typedef digit_t [3:0] alarm_t;
  typedef logic [6:0] seg_t;

  // Request from the datapath to the alarm controller
  typedef struct packed {
    logic       tick;
    logic       key_en;
    logic [7:0] key;
  } ctrl_req_t;

  // Clock digits after the current transaction
  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
  } time_t;

  // Controller state after the current transaction
  typedef struct packed {
    logic   set_mode;
    logic   enable;
    logic   sounding;
    alarm_t alarm;
  } ctrl_stat_t;

  // Active-high seven-segment pattern, bit0 = a .. bit6 = g
  function automatic seg_t seg_of(digit_t d);
    seg_t s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h67;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // Clamp an hour to 23 and split into tens (2 bits) and units (4 bits)
  function automatic logic [5:0] split_hours(logic [4:0] v);
    logic [4:0] c;
    logic [1:0] t;
    logic [4:0] r;
    c = (v > 5'd23) ? 5'd23 : v;
    priority if (c >= 5'd20) t = 2'd2;
    else if (c >= 5'd10)     t = 2'd1;
    else                     t = 2'd0;
    r = c - 5'(t) * 5'd10;
    return {t, r[3:0]};
  endfunction

  // Clamp a minute or second to 59 and split into tens (3 bits) and units
  function automatic logic [6:0] split_sixty(logic [5:0] v);
    logic [5:0] c;
    logic [2:0] t;
    logic [5:0] r;
    c = (v > 6'd59) ? 6'd59 : v;
    priority if (c >= 6'd50) t = 3'd5;
    else if (c >= 6'd40)     t = 3'd4;
    else if (c >= 6'd30)     t = 3'd3;
    else if (c >= 6'd20)     t = 3'd2;
    else if (c >= 6'd10)     t = 3'd1;
    else                     t = 3'd0;
    r = c - 6'(t) * 6'd10;
    return {t, r[3:0]};
  endfunction

endpackage

`default_nettype wire

>>> hdl/bcdac_digit_cell.sv
// ----------------------------------------------------------------------------
// bcdac_digit_cell
// One BCD counter digit of the time chain: increments on carry in, wraps at
// its modulus and hands a carry to the next digit.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdac_digit_cell #(
  parameter int unsigned Width   = 4,
  parameter int unsigned Modulus = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             inc_i,
  input  wire logic             load_i,
  input  wire logic [Width-1:0] load_val_i,
  input  wire logic             clr_i,
  output logic      [Width-1:0] step_o,
  output logic      [Width-1:0] digit_d_o,
  output logic                  carry_o
);

  logic [Width-1:0] digit_q, digit_d;
  logic [Width:0]   sum;
  logic             wrap;

  // Increment and detect the wrap point
  assign sum     = {1'b0, digit_q} + (Width+1)'(1);
  assign wrap    = (sum >= (Width+1)'(Modulus));
  assign carry_o = inc_i && wrap;

  always_comb begin
    if (!inc_i) begin
      step_o = digit_q;
    end else if (wrap) begin
      step_o = '0;
    end else begin
      step_o = sum[Width-1:0];
    end
  end

  // Load beats clear beats step
  always_comb begin
    priority if (load_i) begin
      digit_d = load_val_i;
    end else if (clr_i) begin
      digit_d = '0;
    end else begin
      digit_d = step_o;
    end
  end

  assign digit_d_o = digit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/bcdac_alarm_ctrl.sv
// ----------------------------------------------------------------------------
// bcdac_alarm_ctrl
// Alarm register, set-mode digit entry, enable and ringing latch.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdac_alarm_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire bcdac_pkg::ctrl_req_t  req_i,
  input  wire bcdac_pkg::time_t      time_i,
  output bcdac_pkg::ctrl_stat_t      stat_o
);

  bcdac_pkg::alarm_t alarm_q, alarm_d;
  logic [1:0]        entry_q, entry_d;
  logic              set_mode_q, set_mode_d;
  logic              enable_q, enable_d;
  logic              ringing_q, ringing_d;
  logic              is_digit;
  logic              match;

  assign is_digit = (req_i.key >= bcdac_pkg::KEY_ZERO) &&
                    (req_i.key <= bcdac_pkg::KEY_NINE);

  // Compare the advanced time against the alarm at seconds zero
  assign match = (time_i.second_units == 4'd0) && (time_i.second_tens == 3'd0) &&
                 (time_i.minute_units == alarm_q[bcdac_pkg::ALM_MIN_UNITS]) &&
                 ({1'b0, time_i.minute_tens} == alarm_q[bcdac_pkg::ALM_MIN_TENS]) &&
                 (time_i.hour_units == alarm_q[bcdac_pkg::ALM_HOUR_UNITS]) &&
                 ({2'b00, time_i.hour_tens} == alarm_q[bcdac_pkg::ALM_HOUR_TENS]);

  // Decode keys and latch ringing
  always_comb begin
    alarm_d    = alarm_q;
    entry_d    = entry_q;
    set_mode_d = set_mode_q;
    enable_d   = enable_q;
    ringing_d  = ringing_q;
    if (req_i.tick) begin
      if (enable_q && match) begin
        ringing_d = 1'b1;
      end
    end else if (req_i.key_en) begin
      priority if (req_i.key == bcdac_pkg::KEY_SPACE) begin
        set_mode_d = 1'b1;
        entry_d    = 2'd0;
      end else if (req_i.key == bcdac_pkg::KEY_ENTER) begin
        set_mode_d = 1'b0;
      end else if (req_i.key == bcdac_pkg::KEY_ENABLE) begin
        enable_d = !enable_q;
      end else if (req_i.key == bcdac_pkg::KEY_SILENCE) begin
        ringing_d = 1'b0;
      end else if (set_mode_q && is_digit) begin
        alarm_d[entry_q] = 4'(req_i.key - bcdac_pkg::KEY_ZERO);
        entry_d          = entry_q + 2'd1;
      end
    end
  end

  assign stat_o.set_mode = set_mode_d;
  assign stat_o.enable   = enable_d;
  assign stat_o.sounding = enable_d && ringing_d;
  assign stat_o.alarm    = alarm_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q    <= {4'd0, 4'd0, 4'd2, 4'd1};
      entry_q    <= 2'd0;
      set_mode_q <= 1'b0;
      enable_q   <= 1'b0;
      ringing_q  <= 1'b0;
    end else begin
      alarm_q    <= alarm_d;
      entry_q    <= entry_d;
      set_mode_q <= set_mode_d;
      enable_q   <= enable_d;
      ringing_q  <= ringing_d;
    end
  end

  // Ringing only starts on a tick transaction
  a_ring_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ringing_q) |-> $past(req_i.tick))
    else $error("ringing latched without a tick");

  // Alarm digits change only through digit entry in set mode
  a_alarm_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (alarm_q != $past(alarm_q)) |-> ($past(set_mode_q) && $past(req_i.key_en)))
    else $error("alarm digits changed outside set mode");

  // Entry position moves only on key transactions
  a_entry_on_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_q != $past(entry_q)) |-> $past(req_i.key_en))
    else $error("entry position moved without a key");

endmodule

`default_nettype wire

>>> hdl/bcd_alarm_clock_24h_unit.sv
// ----------------------------------------------------------------------------
// bcd_alarm_clock_24h_unit
// 24-hour BCD alarm clock with seven-segment outputs.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle and its result appears in the output
// register in the next cycle; the input is stalled only while that register
// holds a result the consumer has not yet taken. A tick ripples its carry
// through the chain of six digit cells (seconds, minutes, hours) within that
// cycle, and the alarm compare and the segment decode follow in the same
// cycle, so the carry chain sets the clock period and not the throughput.
`default_nettype none

module bcd_alarm_clock_24h_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            stall_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [7:0] key_i,
  input  wire logic [4:0] load_hours_i,
  input  wire logic [5:0] load_minutes_i,
  input  wire logic [5:0] load_seconds_i,
  output logic            valid_o,
  input  wire logic       stall_i,
  output logic      [6:0] seg_hour_tens_o,
  output logic      [6:0] seg_hour_units_o,
  output logic      [6:0] seg_minute_tens_o,
  output logic      [6:0] seg_minute_units_o,
  output logic      [6:0] seg_second_tens_o,
  output logic      [6:0] seg_second_units_o,
  output logic            setting_alarm_o,
  output logic            alarm_on_o,
  output logic            alarm_sounding_o
);

  logic accept;
  logic tick, load;
  logic out_valid_q;

  logic [5:0] hour_split;
  logic [6:0] min_split, sec_split;

  logic c_su, c_st, c_mu, c_mt, c_hu;
  logic hour_clr;
  logic [1:0] ht_step;
  logic [3:0] hu_step;

  bcdac_pkg::time_t      time_d;
  bcdac_pkg::ctrl_req_t  req;
  bcdac_pkg::ctrl_stat_t stat;

  bcdac_pkg::seg_t seg_ht_q, seg_hu_q, seg_mt_q, seg_mu_q, seg_st_q, seg_su_q;
  logic            set_q, on_q, snd_q;

  // Accept when the output register is free or being drained
  assign stall_o = out_valid_q && stall_i;
  assign accept  = valid_i && !stall_o;
  assign tick    = accept && (cmd_i == bcdac_pkg::CMD_TICK);
  assign load    = accept && (cmd_i == bcdac_pkg::CMD_LOAD);

  assign hour_split = bcdac_pkg::split_hours(load_hours_i);
  assign min_split  = bcdac_pkg::split_sixty(load_minutes_i);
  assign sec_split  = bcdac_pkg::split_sixty(load_seconds_i);

  // Chain of digit cells, seconds units first
  bcdac_digit_cell #(.Width(4), .Modulus(10)) u_sec_units (
    .clk_i, .rst_ni, .inc_i(tick), .load_i(load), .load_val_i(sec_split[3:0]),
    .clr_i(1'b0), .step_o(), .digit_d_o(time_d.second_units), .carry_o(c_su)
  );

  bcdac_digit_cell #(.Width(3), .Modulus(6)) u_sec_tens (
    .clk_i, .rst_ni, .inc_i(c_su), .load_i(load), .load_val_i(sec_split[6:4]),
    .clr_i(1'b0), .step_o(), .digit_d_o(time_d.second_tens), .carry_o(c_st)
  );

  bcdac_digit_cell #(.Width(4), .Modulus(10)) u_min_units (
    .clk_i, .rst_ni, .inc_i(c_st), .load_i(load), .load_val_i(min_split[3:0]),
    .clr_i(1'b0), .step_o(), .digit_d_o(time_d.minute_units), .carry_o(c_mu)
  );

  bcdac_digit_cell #(.Width(3), .Modulus(6)) u_min_tens (
    .clk_i, .rst_ni, .inc_i(c_mu), .load_i(load), .load_val_i(min_split[6:4]),
    .clr_i(1'b0), .step_o(), .digit_d_o(time_d.minute_tens), .carry_o(c_mt)
  );

  bcdac_digit_cell #(.Width(4), .Modulus(10)) u_hour_units (
    .clk_i, .rst_ni, .inc_i(c_mt), .load_i(load), .load_val_i(hour_split[3:0]),
    .clr_i(hour_clr), .step_o(hu_step), .digit_d_o(time_d.hour_units),
    .carry_o(c_hu)
  );

  bcdac_digit_cell #(.Width(2), .Modulus(4)) u_hour_tens (
    .clk_i, .rst_ni, .inc_i(c_hu), .load_i(load), .load_val_i(hour_split[5:4]),
    .clr_i(hour_clr), .step_o(ht_step), .digit_d_o(time_d.hour_tens),
    .carry_o()
  );

  // Wrap the hour pair from 23 to 00 on an hour carry
  assign hour_clr = c_mt && (ht_step == 2'd2) && (hu_step == 4'd4);

  // Alarm controller sees the time after the carry
  assign req.tick   = tick;
  assign req.key_en = accept && (cmd_i == bcdac_pkg::CMD_KEY);
  assign req.key    = key_i;

  bcdac_alarm_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_i(req), .time_i(time_d), .stat_o(stat)
  );

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, shows the alarm time in set mode
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (stat.set_mode) begin
        seg_ht_q <= bcdac_pkg::seg_of(stat.alarm[bcdac_pkg::ALM_HOUR_TENS]);
        seg_hu_q <= bcdac_pkg::seg_of(stat.alarm[bcdac_pkg::ALM_HOUR_UNITS]);
        seg_mt_q <= bcdac_pkg::seg_of(stat.alarm[bcdac_pkg::ALM_MIN_TENS]);
        seg_mu_q <= bcdac_pkg::seg_of(stat.alarm[bcdac_pkg::ALM_MIN_UNITS]);
        seg_st_q <= bcdac_pkg::seg_of(4'd0);
        seg_su_q <= bcdac_pkg::seg_of(4'd0);
      end else begin
        seg_ht_q <= bcdac_pkg::seg_of({2'b00, time_d.hour_tens});
        seg_hu_q <= bcdac_pkg::seg_of(time_d.hour_units);
        seg_mt_q <= bcdac_pkg::seg_of({1'b0, time_d.minute_tens});
        seg_mu_q <= bcdac_pkg::seg_of(time_d.minute_units);
        seg_st_q <= bcdac_pkg::seg_of({1'b0, time_d.second_tens});
        seg_su_q <= bcdac_pkg::seg_of(time_d.second_units);
      end
      set_q <= stat.set_mode;
      on_q  <= stat.enable;
      snd_q <= stat.sounding;
    end
  end

  assign valid_o            = out_valid_q;
  assign seg_hour_tens_o    = seg_ht_q;
  assign seg_hour_units_o   = seg_hu_q;
  assign seg_minute_tens_o  = seg_mt_q;
  assign seg_minute_units_o = seg_mu_q;
  assign seg_second_tens_o  = seg_st_q;
  assign seg_second_units_o = seg_su_q;
  assign setting_alarm_o    = set_q;
  assign alarm_on_o         = on_q;
  assign alarm_sounding_o   = snd_q;

endmodule

`default_nettype wire
